// ===== rtl/mi3_pkg.sv =====
// Shared constants, cofactor index table and the queue transaction type
// of the 3x3 matrix inverse unit. No dependencies.
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_ENT   = 9;
  localparam int ADJ_W     = 64;                  // cofactor magnitude
  localparam int DET_W     = 96;                  // determinant magnitude
  localparam int QW        = 32;                  // quotient bits kept
  localparam int REM_W     = DET_W + QW;          // divider remainder width
  localparam int SHIFT     = 2 * FRAC_BITS;

  // Cofactor i = m[CF[i][0]]*m[CF[i][1]] - m[CF[i][2]]*m[CF[i][3]]
  localparam int unsigned CF [NUM_ENT][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  // One classified matrix handed from front to back
  typedef struct packed {
    logic                              sing;
    logic                              dneg;
    logic [DET_W-1:0]                  dmag;
    logic [NUM_ENT-1:0]                adj_neg;
    logic [NUM_ENT-1:0][ADJ_W-1:0]     adj_mag;
  } mi3_job_t;

endpackage

// ===== rtl/mi3_front.sv =====
// Front end: cofactors, determinant and singular test, six stages.
// Depends on mi3_pkg.
module mi3_front (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  input  logic [mi3_pkg::NUM_ENT-1:0][mi3_pkg::DATA_W-1:0] mat_i,
  input  logic                                             full_i,
  output logic                                             push_o,
  output mi3_pkg::mi3_job_t                                job_o
);
  import mi3_pkg::*;

  logic                    adv;
  logic [5:0]              v_q;
  logic signed [DATA_W-1:0] m [NUM_ENT];

  logic signed [63:0]      prod_q [2*NUM_ENT];
  logic signed [DATA_W-1:0] row1_q [3], row2_q [3];
  logic signed [ADJ_W:0]   adj_q [NUM_ENT];
  logic [ADJ_W-1:0]        mag3_q [NUM_ENT], mag4_q [NUM_ENT], mag5_q [NUM_ENT];
  logic [NUM_ENT-1:0]      neg3_q, neg4_q, neg5_q;
  logic [DATA_W-1:0]       mmag3_q [3];
  logic [2:0]              mneg3_q;
  logic [63:0]             pl4_q [3], ph4_q [3];
  logic [2:0]              tneg4_q;
  logic signed [DET_W:0]   det5_q;
  logic signed [DET_W:0]   term [3];
  logic                    sing_q, dneg_q;
  logic [DET_W-1:0]        dmag_q;
  logic [NUM_ENT-1:0][ADJ_W-1:0] magout_q;
  logic [NUM_ENT-1:0]      negout_q;

  assign adv = !full_i;
  for (genvar k = 0; k < NUM_ENT; k++) begin : g_m
    assign m[k] = mat_i[k];
  end

  // Advance the valid bits along with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[4:0], in_valid_i};
    end
  end

  // Form signed determinant terms from the partial products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      term[j] = $signed({1'b0, DET_W'({ph4_q[j], 32'b0}) + DET_W'(pl4_q[j])});
      if (tneg4_q[j]) term[j] = -term[j];
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        prod_q[2*i]   <= 64'(m[CF[i][0]]) * 64'(m[CF[i][1]]);
        prod_q[2*i+1] <= 64'(m[CF[i][2]]) * 64'(m[CF[i][3]]);
        adj_q[i]      <= (ADJ_W+1)'(prod_q[2*i]) - (ADJ_W+1)'(prod_q[2*i+1]);
        neg3_q[i]     <= adj_q[i][ADJ_W];
        mag3_q[i]     <= adj_q[i][ADJ_W] ? ADJ_W'(-adj_q[i]) : ADJ_W'(adj_q[i]);
      end
      for (int j = 0; j < 3; j++) begin
        row1_q[j]  <= m[j];
        row2_q[j]  <= row1_q[j];
        mneg3_q[j] <= row2_q[j][DATA_W-1];
        mmag3_q[j] <= row2_q[j][DATA_W-1] ? DATA_W'(-row2_q[j]) : DATA_W'(row2_q[j]);
        pl4_q[j]   <= 64'(mmag3_q[j]) * 64'(mag3_q[3*j][31:0]);
        ph4_q[j]   <= 64'(mmag3_q[j]) * 64'(mag3_q[3*j][63:32]);
        tneg4_q[j] <= mneg3_q[j] ^ neg3_q[3*j];
      end
      mag4_q   <= mag3_q;
      neg4_q   <= neg3_q;
      mag5_q   <= mag4_q;
      neg5_q   <= neg4_q;
      det5_q   <= term[0] + term[1] + term[2];
      sing_q   <= (det5_q == '0);
      dneg_q   <= det5_q[DET_W];
      dmag_q   <= det5_q[DET_W] ? DET_W'(-det5_q) : DET_W'(det5_q);
      for (int i = 0; i < NUM_ENT; i++) magout_q[i] <= mag5_q[i];
      negout_q <= neg5_q;
    end
  end

  assign push_o        = adv && v_q[5];
  assign job_o.sing    = sing_q;
  assign job_o.dneg    = dneg_q;
  assign job_o.dmag    = dmag_q;
  assign job_o.adj_neg = negout_q;
  assign job_o.adj_mag = magout_q;

endmodule

// ===== rtl/mi3_queue.sv =====
// Two-entry transaction queue between front and back end.
// Depends on mi3_pkg.
module mi3_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mi3_pkg::mi3_job_t job_i,
  output logic              full_o,
  output logic              pop_o,
  output mi3_pkg::mi3_job_t job_o
);
  import mi3_pkg::*;

  mi3_job_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign pop_o  = (cnt_q != 2'd0);
  assign job_o  = mem_q[rd_q];

  // Track pointers and fill level; the back end drains every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_o)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_o);
    end
  end

  // Store transaction
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// ===== rtl/mi3_back.sv =====
// Back end: nine pipelined restoring dividers, one quotient bit a stage,
// then saturation and the result register. Depends on mi3_pkg.
module mi3_back (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  input  mi3_pkg::mi3_job_t                                job_i,
  output logic                                             valid_o,
  output logic [mi3_pkg::NUM_ENT-1:0][mi3_pkg::DATA_W-1:0] inv_o,
  output logic                                             singular_o,
  output logic                                             overflow_o
);
  import mi3_pkg::*;

  logic [REM_W-1:0]   rem_q [QW+1][NUM_ENT];
  logic [QW-1:0]      q_q   [QW+1][NUM_ENT];
  logic [NUM_ENT-1:0] ovf_q [QW+1];
  logic [NUM_ENT-1:0] neg_q [QW+1];
  logic [DET_W-1:0]   dmag_q [QW+1];
  logic [QW:0]        v_q;
  logic               sing_q [QW+1];

  logic [NUM_ENT-1:0][DATA_W-1:0] res;
  logic [NUM_ENT-1:0]             sat;
  logic                           valid_q, singular_q, overflow_q;
  logic [NUM_ENT-1:0][DATA_W-1:0] inv_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      v_q     <= {v_q[QW-1:0], in_valid_i};
      valid_q <= v_q[QW];
    end
  end

  // Load numerators and flag quotients of 2^32 or more
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_ENT; i++) begin
      rem_q[0][i] <= REM_W'(job_i.adj_mag[i]) << SHIFT;
      q_q[0][i]   <= '0;
      ovf_q[0][i] <= (REM_W'(job_i.adj_mag[i]) << SHIFT) >= {job_i.dmag, {QW{1'b0}}};
      neg_q[0][i] <= job_i.adj_neg[i] ^ job_i.dneg;
    end
    dmag_q[0] <= job_i.dmag;
    sing_q[0] <= job_i.sing;
  end

  // One compare and subtract per lane per stage
  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int SH = QW - s;
    logic [REM_W-1:0] dsh;
    assign dsh = REM_W'(dmag_q[s-1]) << SH;
    always_ff @(posedge clk_i) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        if (rem_q[s-1][i] >= dsh) begin
          rem_q[s][i] <= rem_q[s-1][i] - dsh;
          q_q[s][i]   <= q_q[s-1][i] | (QW'(1) << SH);
        end else begin
          rem_q[s][i] <= rem_q[s-1][i];
          q_q[s][i]   <= q_q[s-1][i];
        end
      end
      ovf_q[s]  <= ovf_q[s-1];
      neg_q[s]  <= neg_q[s-1];
      dmag_q[s] <= dmag_q[s-1];
      sing_q[s] <= sing_q[s-1];
    end
  end

  // Saturate and apply the sign; a singular matrix gives zeros and no saturation
  always_comb begin
    for (int i = 0; i < NUM_ENT; i++) begin
      if (neg_q[QW][i]) begin
        sat[i] = ovf_q[QW][i] || (q_q[QW][i] > 32'h8000_0000);
        res[i] = sat[i] ? 32'h8000_0000 : (32'd0 - q_q[QW][i]);
      end else begin
        sat[i] = ovf_q[QW][i] || (q_q[QW][i] > 32'h7FFF_FFFF);
        res[i] = sat[i] ? 32'h7FFF_FFFF : q_q[QW][i];
      end
      if (sing_q[QW]) begin
        sat[i] = 1'b0;
        res[i] = '0;
      end
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk_i) begin
    inv_q      <= res;
    singular_q <= sing_q[QW];
    overflow_q <= |sat;
  end

  assign valid_o    = valid_q;
  assign inv_o      = inv_q;
  assign singular_o = singular_q;
  assign overflow_o = overflow_q;

endmodule

// ===== rtl/matrix_inverse_3x3_unit.sv =====
// Top level of the 3x3 matrix inverse unit (adjugate method, Q16.16).
// Depends on mi3_pkg, mi3_front, mi3_queue and mi3_back.
//
// Takes one matrix per clock cycle while busy_o is low and returns one
// result per matrix, in order, on a one-cycle valid_o strobe; the receiver
// cannot stall. The path runs through six front stages (cofactor products,
// determinant partial products and sum), the queue, a load stage, one back
// stage per quotient bit of the nine restoring dividers, and the result register.
// The back end drains the queue every cycle, so busy_o stays low in use.
module matrix_inverse_3x3_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] a00_i, input logic [31:0] a01_i, input logic [31:0] a02_i,
  input  logic [31:0] a10_i, input logic [31:0] a11_i, input logic [31:0] a12_i,
  input  logic [31:0] a20_i, input logic [31:0] a21_i, input logic [31:0] a22_i,
  output logic        valid_o,
  output logic [31:0] inv00_o, output logic [31:0] inv01_o, output logic [31:0] inv02_o,
  output logic [31:0] inv10_o, output logic [31:0] inv11_o, output logic [31:0] inv12_o,
  output logic [31:0] inv20_o, output logic [31:0] inv21_o, output logic [31:0] inv22_o,
  output logic        singular_o,
  output logic        overflow_o
);
  import mi3_pkg::*;

  logic [NUM_ENT-1:0][DATA_W-1:0] mat, inv;
  logic     full, push, pop;
  mi3_job_t fjob, bjob;

  assign mat = {a22_i, a21_i, a20_i, a12_i, a11_i, a10_i, a02_i, a01_i, a00_i};
  assign busy_o = full;

  mi3_front u_front (
    .clk_i, .rst_ni, .in_valid_i(start_i && !full), .mat_i(mat),
    .full_i(full), .push_o(push), .job_o(fjob)
  );

  mi3_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(fjob),
    .full_o(full), .pop_o(pop), .job_o(bjob)
  );

  mi3_back u_back (
    .clk_i, .rst_ni, .in_valid_i(pop), .job_i(bjob),
    .valid_o, .inv_o(inv), .singular_o, .overflow_o
  );

  assign inv00_o = inv[0];
  assign inv01_o = inv[1];
  assign inv02_o = inv[2];
  assign inv10_o = inv[3];
  assign inv11_o = inv[4];
  assign inv12_o = inv[5];
  assign inv20_o = inv[6];
  assign inv21_o = inv[7];
  assign inv22_o = inv[8];

endmodule

// ===== dv/tb_matrix_inverse_3x3_unit.sv =====
// Testbench for matrix_inverse_3x3_unit: drives matrices, computes the exact
// adjugate inverse on the side and checks every result. Depends on mi3_pkg.
`timescale 1ns / 100ps

module tb_matrix_inverse_3x3_unit;
  import mi3_pkg::*;

  typedef logic [DATA_W-1:0] ent_t;

  typedef struct {
    ent_t a [NUM_ENT];
  } matrix_t;

  typedef struct {
    ent_t inv [NUM_ENT];
    logic sing;
    logic ovf;
  } inverse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, valid_o, singular_o, overflow_o;
  ent_t a_q [NUM_ENT] = '{default: '0};
  ent_t inv_w [NUM_ENT];

  matrix_t  pending_mats [$];
  inverse_t expected_invs [$];
  matrix_t  mt_of_start;
  int       gap_cnt = 0;
  int       hold_off = 0;
  int       n_errors = 0;
  int       n_results = 0;
  int       n_sing = 0;
  int       n_ovf = 0;

  matrix_inverse_3x3_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .a00_i(a_q[0]), .a01_i(a_q[1]), .a02_i(a_q[2]),
    .a10_i(a_q[3]), .a11_i(a_q[4]), .a12_i(a_q[5]),
    .a20_i(a_q[6]), .a21_i(a_q[7]), .a22_i(a_q[8]),
    .valid_o(valid_o),
    .inv00_o(inv_w[0]), .inv01_o(inv_w[1]), .inv02_o(inv_w[2]),
    .inv10_o(inv_w[3]), .inv11_o(inv_w[4]), .inv12_o(inv_w[5]),
    .inv20_o(inv_w[6]), .inv21_o(inv_w[7]), .inv22_o(inv_w[8]),
    .singular_o(singular_o), .overflow_o(overflow_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Exact adjugate inverse, truncated toward zero and saturated
  function automatic inverse_t invert_matrix(matrix_t mt);
    logic signed [63:0]  m [NUM_ENT];
    logic signed [127:0] cof [NUM_ENT];
    logic signed [127:0] det, q;
    logic        [127:0] dmag, nmag, qmag;
    inverse_t r;
    for (int i = 0; i < NUM_ENT; i++) m[i] = $signed(mt.a[i]);
    cof[0] = m[4] * m[8] - m[7] * m[5];
    cof[1] = m[2] * m[7] - m[1] * m[8];
    cof[2] = m[1] * m[5] - m[2] * m[4];
    cof[3] = m[5] * m[6] - m[3] * m[8];
    cof[4] = m[0] * m[8] - m[2] * m[6];
    cof[5] = m[3] * m[2] - m[0] * m[5];
    cof[6] = m[3] * m[7] - m[6] * m[4];
    cof[7] = m[6] * m[1] - m[0] * m[7];
    cof[8] = m[0] * m[4] - m[3] * m[1];
    det = m[0] * cof[0] + m[1] * cof[3] + m[2] * cof[6];
    r.sing = (det == 0);
    r.ovf = 1'b0;
    for (int i = 0; i < NUM_ENT; i++) r.inv[i] = '0;
    if (!r.sing) begin
      dmag = det < 0 ? -det : det;
      for (int i = 0; i < NUM_ENT; i++) begin
        nmag = (cof[i] < 0 ? -cof[i] : cof[i]) << SHIFT;
        qmag = nmag / dmag;
        q = ((cof[i] < 0) != (det < 0)) ? -$signed(qmag) : $signed(qmag);
        if (q > 128'sh7FFF_FFFF) begin
          r.inv[i] = 32'h7FFF_FFFF;
          r.ovf = 1'b1;
        end else if (q < -128'sh8000_0000) begin
          r.inv[i] = 32'h8000_0000;
          r.ovf = 1'b1;
        end else begin
          r.inv[i] = q[31:0];
        end
      end
    end
    return r;
  endfunction

  function automatic ent_t rand_entry();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      6, 7: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  // Queue one matrix for the driver; its expected inverse is recorded on acceptance
  task automatic push_matrix(matrix_t mt);
    pending_mats.push_back(mt);
  endtask

  // Drive: random gaps, one pause until drained
  always @(posedge clk_i) begin
    matrix_t mt;
    if (rst_ni) begin
      if (start_i && !busy_o) expected_invs.push_back(invert_matrix(mt_of_start));
      if (start_i && busy_o) begin
        // hold the transaction
      end else if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        start_i <= 1'b0;
      end else if (hold_off > 0 && hold_off == pending_mats.size()
                   && expected_invs.size() + (start_i ? 1 : 0) != 0) begin
        start_i <= 1'b0;
      end else if (pending_mats.size() > 0) begin
        mt = pending_mats.pop_front();
        for (int i = 0; i < NUM_ENT; i++) a_q[i] <= mt.a[i];
        mt_of_start = mt;
        start_i <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          gap_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(1, 3);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Check each result strobe against the oldest expectation
  always @(posedge clk_i) begin
    inverse_t ex;
    if (rst_ni && valid_o) begin
      if (expected_invs.size() == 0) begin
        $error("result with no matrix outstanding");
        n_errors++;
      end else begin
        ex = expected_invs.pop_front();
        n_results++;
        if (ex.sing) n_sing++;
        if (ex.ovf) n_ovf++;
        for (int i = 0; i < NUM_ENT; i++)
          if (inv_w[i] !== ex.inv[i]) begin
            $error("inv%0d%0d: expected %h actual %h", i / 3, i % 3, ex.inv[i], inv_w[i]);
            n_errors++;
          end
        if (singular_o !== ex.sing) begin
          $error("singular: expected %b actual %b", ex.sing, singular_o);
          n_errors++;
        end
        if (overflow_o !== ex.ovf) begin
          $error("overflow: expected %b actual %b", ex.ovf, overflow_o);
          n_errors++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    matrix_t mt;
    int k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // identity, scaled identity, zero, extremes, small diagonal, singular rows
    for (int d = 0; d < 22; d++) begin
      for (int i = 0; i < NUM_ENT; i++) mt.a[i] = '0;
      case (d)
        0: for (int i = 0; i < 3; i++) mt.a[4 * i] = 32'h0001_0000;
        1: for (int i = 0; i < 3; i++) mt.a[4 * i] = 32'hFFFE_0000;
        2: ;
        3: for (int i = 0; i < NUM_ENT; i++) mt.a[i] = 32'h8000_0000;
        4: for (int i = 0; i < 3; i++) mt.a[4 * i] = 32'h8000_0000;
        5: for (int i = 0; i < 3; i++) mt.a[4 * i] = 32'h7FFF_FFFF;
        6: for (int i = 0; i < 3; i++) mt.a[4 * i] = 32'h0000_0001;
        7: for (int i = 0; i < 3; i++) mt.a[4 * i] = 32'hFFFF_FFFF;
        8: begin
          for (int i = 0; i < 3; i++) mt.a[4 * i] = 32'h0000_0001;
          mt.a[0] = 32'h8000_0000;
        end
        9: begin
          mt.a[0] = 32'h0000_8000; mt.a[4] = 32'h0002_0000; mt.a[8] = 32'h0001_0000;
        end
        10: begin
          mt.a[2] = 32'h0001_0000; mt.a[4] = 32'h0001_0000; mt.a[6] = 32'h0001_0000;
        end
        11: for (int i = 0; i < NUM_ENT; i++) mt.a[i] = 32'h7FFF_FFFF;
        default: begin
          for (int i = 0; i < 6; i++) mt.a[i] = rand_entry();
          for (int i = 0; i < 3; i++) mt.a[6 + i] = (d & 1) ? mt.a[i] : mt.a[3 + i];
        end
      endcase
      push_matrix(mt);
    end
    // random matrices; hold off once midway until drained
    for (k = 0; k < 850; k++) begin
      for (int i = 0; i < NUM_ENT; i++) mt.a[i] = rand_entry();
      if ($urandom_range(0, 9) == 0)
        for (int i = 0; i < 3; i++) mt.a[3 + i] = mt.a[i];
      push_matrix(mt);
    end
    hold_off = 425;
    while (pending_mats.size() > 0 || start_i) @(posedge clk_i);
    while (expected_invs.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("checked %0d inverses: %0d singular, %0d saturated", n_results, n_sing, n_ovf);
    if (n_errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== matrix_inverse_3x3_unit.f =====
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_queue.sv
rtl/mi3_back.sv
rtl/matrix_inverse_3x3_unit.sv
dv/tb_matrix_inverse_3x3_unit.sv
